### rtl/pbta_pkg.sv
package pbta_pkg;

   localparam int PIXEL_BITS      = 10;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int ATAN_ITERATIONS = 16;

   localparam int DIST_W  = 18;
   localparam int SCALE_W = 20;

   // offsets: centre +/- half size - lens centre, signed
   localparam int OFS_W   = PIXEL_BITS + 2;
   localparam int SQ_W    = 2 * PIXEL_BITS + 2;
   localparam int RPROD_W = DIST_W + SQ_W;
   localparam int RAD_W   = RPROD_W + 1;
   localparam int PROD_W  = SCALE_W + 1 + OFS_W;
   localparam int MAG_W   = SCALE_W + PIXEL_BITS + 1;
   localparam int SUMN_W  = PROD_W + 1;

   // denominator in Q0.32, unity plus one bit
   localparam int ONE_SHIFT = 32;
   localparam int DEN_W     = ONE_SHIFT + 1;
   localparam logic [DEN_W-1:0] ONE_Q32 = DEN_W'(1) << ONE_SHIFT;

   // plane value = min(mag * 2^32 / D, 2^48), one quotient bit per divider cell
   localparam int QUOT_W    = 48;
   localparam int DIV_STEPS = QUOT_W;
   localparam int MAG_SHIFT = QUOT_W - ONE_SHIFT;
   localparam int PLANE_W   = QUOT_W + 1;
   localparam logic [PLANE_W-1:0] PLANE_LIMIT = PLANE_W'(1) << QUOT_W;

   // arctangent datapath
   localparam int SUM_W        = PLANE_W + 2;
   localparam int CORDIC_W     = SUM_W + 2;
   localparam int X_INIT_SHIFT = 25;
   localparam int Z_W          = 33;
   localparam int STAGE_IDX_W  = (ATAN_ITERATIONS > 1) ? $clog2(ATAN_ITERATIONS) : 1;
   localparam int ANGLE_SHIFT  = 30 - ANGLE_FRAC_BITS;
   localparam int ANGLE_W      = ANGLE_FRAC_BITS + 2;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint ANGLE_MAX_L =
      (HALF_PI_Q30 + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
   localparam logic signed [Z_W:0]       ANGLE_MAX_Z = (Z_W+1)'(ANGLE_MAX_L);
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX_A = ANGLE_W'(ANGLE_MAX_L);
   localparam logic signed [Z_W:0]       ROUND_HALF  = (Z_W+1)'(1) <<< (ANGLE_SHIFT - 1);

   // configuration
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OCX    = 3'd0,
      REG_OCY    = 3'd1,
      REG_DISTX  = 3'd2,
      REG_DISTY  = 3'd3,
      REG_SCALEX = 3'd4,
      REG_SCALEY = 3'd5
   } csr_reg_type;

   localparam logic [PIXEL_BITS-1:0] OCX_RESET    = PIXEL_BITS'(160);
   localparam logic [PIXEL_BITS-1:0] OCY_RESET    = PIXEL_BITS'(100);
   localparam logic [DIST_W-1:0]     DISTX_RESET  = DIST_W'(19027);
   localparam logic [DIST_W-1:0]     DISTY_RESET  = DIST_W'(20587);
   localparam logic [SCALE_W-1:0]    SCALEX_RESET = SCALE_W'(49305);
   localparam logic [SCALE_W-1:0]    SCALEY_RESET = SCALE_W'(51285);

   typedef struct packed {
      logic healthy;
      logic err;
      logic sat_x_pos;
      logic sat_x_neg;
      logic sat_y_pos;
      logic sat_y_neg;
   } tag_type;

   typedef struct packed {
      logic [DEN_W-1:0]     rem;
      logic [DEN_W-1:0]     den;
      logic [MAG_SHIFT-1:0] bits;
      logic [QUOT_W-1:0]    quot;
      logic                 ovf;
      logic                 neg;
   } div_lane_type;

   // lanes: 0 x near corner, 1 x far corner, 2 y near corner, 3 y far corner
   typedef struct packed {
      tag_type                tag;
      div_lane_type [3:0]     lane;
   } div_stage_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [Z_W-1:0]      z;
   } cordic_axis_type;

   typedef struct packed {
      tag_type               tag;
      cordic_axis_type [1:0] axis;
   } cordic_stage_type;

   // atan(2^-i) in Q.30
   function automatic logic [Z_W-1:0] atan_q30(input int unsigned i);
      logic [Z_W-1:0] v;
      case (i)
         0:       v = Z_W'(843314857);
         1:       v = Z_W'(497837829);
         2:       v = Z_W'(263043837);
         3:       v = Z_W'(133525159);
         4:       v = Z_W'(67021687);
         5:       v = Z_W'(33543516);
         6:       v = Z_W'(16775851);
         7:       v = Z_W'(8388437);
         8:       v = Z_W'(4194283);
         9:       v = Z_W'(2097149);
         10:      v = Z_W'(1048576);
         11:      v = Z_W'(524288);
         12:      v = Z_W'(262144);
         13:      v = Z_W'(131072);
         14:      v = Z_W'(65536);
         15:      v = Z_W'(32768);
         16:      v = Z_W'(16384);
         17:      v = Z_W'(8192);
         18:      v = Z_W'(4096);
         19:      v = Z_W'(2048);
         20:      v = Z_W'(1024);
         21:      v = Z_W'(512);
         22:      v = Z_W'(256);
         23:      v = Z_W'(128);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/pbta_if.sv
interface pbta_req_if;
   logic                            valid;
   logic                            ready;
   logic                            target_healthy;
   logic [pbta_pkg::PIXEL_BITS-1:0] box_center_x;
   logic [pbta_pkg::PIXEL_BITS-1:0] box_center_y;
   logic [pbta_pkg::PIXEL_BITS-1:0] box_width;
   logic [pbta_pkg::PIXEL_BITS-1:0] box_height;

   modport source (output valid, target_healthy, box_center_x, box_center_y,
                   box_width, box_height, input ready);
   modport sink   (input valid, target_healthy, box_center_x, box_center_y,
                   box_width, box_height, output ready);
endinterface

interface pbta_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                angles_valid;
   logic signed [pbta_pkg::ANGLE_W-1:0] angle_x;
   logic signed [pbta_pkg::ANGLE_W-1:0] angle_y;
   logic                                denominator_error;

   modport source (output valid, angles_valid, angle_x, angle_y, denominator_error,
                   input ready);
   modport sink   (input valid, angles_valid, angle_x, angle_y, denominator_error,
                   output ready);
endinterface

interface pbta_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pbta_pkg::CSR_IDX_W-1:0]  index;
   logic [pbta_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pixel_box_to_target_angles.sv
// Pixel box to target angles.
// req_chan: one target report per transfer (healthy flag, box centre, box size).
// rsp_chan: one result per report (valid flag, x/y angle in signed Q2.13 radians,
//           denominator error). Results leave in the order reports came in.
// csr_chan: register writes (index 0..5: lens centre x/y, distortion x/y,
//           scale x/y); always ready, take effect on the next report.
//           Write only while no report is in flight.
// Throughput: one report per cycle while req_chan.ready is high. Path from the
// accepting edge to rsp_chan.valid: registers a to e, the chain of 48 one-bit
// divider cells, register f, 16 CORDIC cells and the output register.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// When the receiver stalls, the output register holds its result; the chain
// keeps moving and taking reports while its last cell is empty and stops
// (req_chan.ready low) only when a finished result is waiting behind it.
module pixel_box_to_target_angles (
   input  logic        clock,
   input  logic        reset,
   pbta_req_if.sink    req_chan,
   pbta_rsp_if.source  rsp_chan,
   pbta_csr_if.sink    csr_chan
);

   localparam int NSTEP = pbta_pkg::DIV_STEPS;
   localparam int NITER = pbta_pkg::ATAN_ITERATIONS;

   // configuration registers
   logic [pbta_pkg::PIXEL_BITS-1:0] ocx_ff, ocy_ff;
   logic [pbta_pkg::DIST_W-1:0]     distx_ff, disty_ff;
   logic [pbta_pkg::SCALE_W-1:0]    scalex_ff, scaley_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ocx_ff    <= pbta_pkg::OCX_RESET;
         ocy_ff    <= pbta_pkg::OCY_RESET;
         distx_ff  <= pbta_pkg::DISTX_RESET;
         disty_ff  <= pbta_pkg::DISTY_RESET;
         scalex_ff <= pbta_pkg::SCALEX_RESET;
         scaley_ff <= pbta_pkg::SCALEY_RESET;
      end else if (csr_chan.valid) begin
         unique case (pbta_pkg::csr_reg_type'(csr_chan.index))
            pbta_pkg::REG_OCX:    ocx_ff    <= csr_chan.data[pbta_pkg::PIXEL_BITS-1:0];
            pbta_pkg::REG_OCY:    ocy_ff    <= csr_chan.data[pbta_pkg::PIXEL_BITS-1:0];
            pbta_pkg::REG_DISTX:  distx_ff  <= csr_chan.data[pbta_pkg::DIST_W-1:0];
            pbta_pkg::REG_DISTY:  disty_ff  <= csr_chan.data[pbta_pkg::DIST_W-1:0];
            pbta_pkg::REG_SCALEX: scalex_ff <= csr_chan.data[pbta_pkg::SCALE_W-1:0];
            pbta_pkg::REG_SCALEY: scaley_ff <= csr_chan.data[pbta_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic advance;
   logic accept;
   logic rsp_valid_ff;
   logic [NITER:0] cor_valid;

   assign advance        = !(cor_valid[NITER] && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   // corner offsets
   logic signed [pbta_pkg::OFS_W-1:0] px_s, py_s, hx_s, hy_s, ocx_s, ocy_s;
   logic signed [pbta_pkg::OFS_W-1:0] a_d_in [4];

   assign px_s  = {2'b00, req_chan.box_center_x};
   assign py_s  = {2'b00, req_chan.box_center_y};
   assign hx_s  = {3'b000, req_chan.box_width[pbta_pkg::PIXEL_BITS-1:1]};
   assign hy_s  = {3'b000, req_chan.box_height[pbta_pkg::PIXEL_BITS-1:1]};
   assign ocx_s = {2'b00, ocx_ff};
   assign ocy_s = {2'b00, ocy_ff};
   assign a_d_in[0] = px_s - hx_s - ocx_s;
   assign a_d_in[1] = px_s + hx_s - ocx_s;
   assign a_d_in[2] = py_s - hy_s - ocy_s;
   assign a_d_in[3] = py_s + hy_s - ocy_s;

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic a_healthy_ff, b_healthy_ff, c_healthy_ff, d_healthy_ff;
   logic signed [pbta_pkg::OFS_W-1:0]   a_d_ff [4];
   logic [pbta_pkg::SQ_W-1:0]           b_sq_ff [4];
   logic signed [pbta_pkg::PROD_W-1:0]  b_n_ff [4];
   logic [pbta_pkg::RPROD_W-1:0]        c_r_ff [4];
   logic signed [pbta_pkg::PROD_W-1:0]  c_n_ff [4];
   logic [pbta_pkg::RAD_W-1:0]          d_r_ff [2];
   logic signed [pbta_pkg::PROD_W-1:0]  d_n_ff [4];
   pbta_pkg::div_stage_type             e_stage_ff;
   pbta_pkg::div_stage_type             e_stage_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_healthy_ff <= req_chan.target_healthy;
         b_healthy_ff <= a_healthy_ff;
         c_healthy_ff <= b_healthy_ff;
         d_healthy_ff <= c_healthy_ff;
         for (int j = 0; j < 4; j++) begin
            a_d_ff[j]  <= a_d_in[j];
            b_sq_ff[j] <= pbta_pkg::SQ_W'(a_d_ff[j] * a_d_ff[j]);
            b_n_ff[j]  <= pbta_pkg::PROD_W'($signed({1'b0, (j < 2) ? scalex_ff : scaley_ff})
                                             * a_d_ff[j]);
            c_r_ff[j]  <= pbta_pkg::RPROD_W'(((j < 2) ? distx_ff : disty_ff) * b_sq_ff[j]);
            c_n_ff[j]  <= b_n_ff[j];
            d_n_ff[j]  <= c_n_ff[j];
         end
         // radial term per corner: x and y parts together
         d_r_ff[0]  <= {1'b0, c_r_ff[0]} + {1'b0, c_r_ff[2]};
         d_r_ff[1]  <= {1'b0, c_r_ff[1]} + {1'b0, c_r_ff[3]};
         e_stage_ff <= e_stage_in;
      end
   end

   // divider set-up: denominator, magnitude, overflow of the 2^48 clamp
   always_comb begin
      logic [pbta_pkg::RAD_W-1:0]          r;
      logic signed [pbta_pkg::PROD_W-1:0]  n;
      logic [pbta_pkg::PROD_W-1:0]         absn;
      logic [pbta_pkg::MAG_W-1:0]          mag;
      logic [pbta_pkg::DEN_W-1:0]          high_part;
      logic [pbta_pkg::DEN_W-1:0]          ovf_sum;
      logic [1:0]                          pos;
      logic signed [pbta_pkg::SUMN_W-1:0]  sn_x;
      logic signed [pbta_pkg::SUMN_W-1:0]  sn_y;
      for (int k = 0; k < 2; k++) begin
         pos[k] = d_r_ff[k][pbta_pkg::RAD_W-1:pbta_pkg::ONE_SHIFT] == '0;
      end
      e_stage_in = '0;
      for (int j = 0; j < 4; j++) begin
         r         = d_r_ff[j % 2];
         n         = d_n_ff[j];
         absn      = n[pbta_pkg::PROD_W-1] ? pbta_pkg::PROD_W'(-n) : pbta_pkg::PROD_W'(n);
         mag       = absn[pbta_pkg::MAG_W-1:0];
         high_part = pbta_pkg::DEN_W'(mag[pbta_pkg::MAG_W-1:pbta_pkg::MAG_SHIFT]);
         ovf_sum   = pbta_pkg::DEN_W'(r[pbta_pkg::ONE_SHIFT-1:0]) + high_part;
         e_stage_in.lane[j].rem  = high_part;
         e_stage_in.lane[j].den  = pbta_pkg::ONE_Q32
                                   - pbta_pkg::DEN_W'(r[pbta_pkg::ONE_SHIFT-1:0]);
         e_stage_in.lane[j].bits = mag[pbta_pkg::MAG_SHIFT-1:0];
         e_stage_in.lane[j].quot = '0;
         e_stage_in.lane[j].ovf  = ovf_sum[pbta_pkg::ONE_SHIFT];
         e_stage_in.lane[j].neg  = n[pbta_pkg::PROD_W-1];
      end
      sn_x = pbta_pkg::SUMN_W'(d_n_ff[0]) + pbta_pkg::SUMN_W'(d_n_ff[1]);
      sn_y = pbta_pkg::SUMN_W'(d_n_ff[2]) + pbta_pkg::SUMN_W'(d_n_ff[3]);
      e_stage_in.tag.healthy   = d_healthy_ff;
      e_stage_in.tag.err       = !(pos[0] && pos[1]);
      e_stage_in.tag.sat_x_pos = sn_x > 0;
      e_stage_in.tag.sat_x_neg = sn_x < 0;
      e_stage_in.tag.sat_y_pos = sn_y > 0;
      e_stage_in.tag.sat_y_neg = sn_y < 0;
   end

   // divider chain
   logic [NSTEP:0]          div_valid;
   pbta_pkg::div_stage_type div_stage [NSTEP+1];

   assign div_valid[0] = e_valid_ff;
   assign div_stage[0] = e_stage_ff;

   for (genvar i = 0; i < NSTEP; i++) begin : g_div
      pbta_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (div_valid[i]),
         .in_stage  (div_stage[i]),
         .out_valid (div_valid[i+1]),
         .out_stage (div_stage[i+1])
      );
   end

   // signed plane values, sum of the two corners per axis, CORDIC start vector
   logic                       f_valid_ff;
   pbta_pkg::cordic_stage_type f_stage_ff;
   pbta_pkg::cordic_stage_type f_stage_in;

   always_comb begin
      logic [pbta_pkg::PLANE_W-1:0]       p;
      logic signed [pbta_pkg::SUM_W-1:0]  pl [4];
      logic signed [pbta_pkg::SUM_W-1:0]  s;
      for (int j = 0; j < 4; j++) begin
         p     = div_stage[NSTEP].lane[j].ovf ? pbta_pkg::PLANE_LIMIT
                                              : {1'b0, div_stage[NSTEP].lane[j].quot};
         pl[j] = div_stage[NSTEP].lane[j].neg ? -$signed(pbta_pkg::SUM_W'(p))
                                              : $signed(pbta_pkg::SUM_W'(p));
      end
      f_stage_in.tag = div_stage[NSTEP].tag;
      for (int a = 0; a < 2; a++) begin
         s = pl[2*a] + pl[2*a+1];
         f_stage_in.axis[a].x = pbta_pkg::CORDIC_W'(1) <<< pbta_pkg::X_INIT_SHIFT;
         f_stage_in.axis[a].y = pbta_pkg::CORDIC_W'(s);
         f_stage_in.axis[a].z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= div_valid[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_stage_ff <= f_stage_in;
      end
   end

   // CORDIC chain
   pbta_pkg::cordic_stage_type cor_stage [NITER+1];

   assign cor_valid[0] = f_valid_ff;
   assign cor_stage[0] = f_stage_ff;

   for (genvar i = 0; i < NITER; i++) begin : g_cordic
      pbta_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (pbta_pkg::STAGE_IDX_W'(i)),
         .in_valid  (cor_valid[i]),
         .in_stage  (cor_stage[i]),
         .out_valid (cor_valid[i+1]),
         .out_stage (cor_stage[i+1])
      );
   end

   // round, clamp, apply error and health
   logic signed [pbta_pkg::ANGLE_W-1:0] angle_in [2];

   always_comb begin
      logic signed [pbta_pkg::Z_W:0] zr;
      logic                          sat_pos;
      logic                          sat_neg;
      for (int a = 0; a < 2; a++) begin
         zr = ($signed(pbta_pkg::Z_W'(cor_stage[NITER].axis[a].z)) + pbta_pkg::ROUND_HALF)
              >>> pbta_pkg::ANGLE_SHIFT;
         if (zr > pbta_pkg::ANGLE_MAX_Z) begin
            zr = pbta_pkg::ANGLE_MAX_Z;
         end else if (zr < -pbta_pkg::ANGLE_MAX_Z) begin
            zr = -pbta_pkg::ANGLE_MAX_Z;
         end
         sat_pos = (a == 0) ? cor_stage[NITER].tag.sat_x_pos : cor_stage[NITER].tag.sat_y_pos;
         sat_neg = (a == 0) ? cor_stage[NITER].tag.sat_x_neg : cor_stage[NITER].tag.sat_y_neg;
         priority if (!cor_stage[NITER].tag.healthy) begin
            angle_in[a] = '0;
         end else if (cor_stage[NITER].tag.err) begin
            angle_in[a] = sat_pos ? pbta_pkg::ANGLE_MAX_A
                        : sat_neg ? -pbta_pkg::ANGLE_MAX_A : '0;
         end else begin
            angle_in[a] = zr[pbta_pkg::ANGLE_W-1:0];
         end
      end
   end

   // output register
   logic                                angles_valid_ff;
   logic                                denom_err_ff;
   logic signed [pbta_pkg::ANGLE_W-1:0] angle_x_ff;
   logic signed [pbta_pkg::ANGLE_W-1:0] angle_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_valid_ff <= cor_valid[NITER];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_chan.ready) begin
         angles_valid_ff <= cor_stage[NITER].tag.healthy;
         denom_err_ff    <= cor_stage[NITER].tag.healthy && cor_stage[NITER].tag.err;
         angle_x_ff      <= angle_in[0];
         angle_y_ff      <= angle_in[1];
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.angles_valid      = angles_valid_ff;
   assign rsp_chan.angle_x           = angle_x_ff;
   assign rsp_chan.angle_y           = angle_y_ff;
   assign rsp_chan.denominator_error = denom_err_ff;

`ifndef SYNTHESIS
   a_err_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.denominator_error |-> rsp_chan.angles_valid)
      else $error("denominator error on an unhealthy report");

   a_unhealthy_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.angles_valid |->
         rsp_chan.angle_x == '0 && rsp_chan.angle_y == '0)
      else $error("non-zero angle on an unhealthy report");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         $signed(rsp_chan.angle_x) <= pbta_pkg::ANGLE_MAX_A &&
         $signed(rsp_chan.angle_x) >= -pbta_pkg::ANGLE_MAX_A &&
         $signed(rsp_chan.angle_y) <= pbta_pkg::ANGLE_MAX_A &&
         $signed(rsp_chan.angle_y) >= -pbta_pkg::ANGLE_MAX_A)
      else $error("angle beyond clamp");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("input held off without an output stall");
`endif

endmodule

### rtl/pbta_div_cell.sv
module pbta_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  pbta_pkg::div_stage_type in_stage,
   output logic                    out_valid,
   output pbta_pkg::div_stage_type out_stage
);

   logic                    valid_ff;
   pbta_pkg::div_stage_type stage_ff;
   pbta_pkg::div_stage_type stage_in;

   // one restoring step per lane: shift in the next numerator bit
   always_comb begin
      logic [pbta_pkg::DEN_W:0] trial;
      logic                     fits;
      stage_in     = in_stage;
      for (int j = 0; j < 4; j++) begin
         trial = {in_stage.lane[j].rem, in_stage.lane[j].bits[pbta_pkg::MAG_SHIFT-1]};
         fits  = trial >= {1'b0, in_stage.lane[j].den};
         stage_in.lane[j].rem  = fits ? pbta_pkg::DEN_W'(trial - {1'b0, in_stage.lane[j].den})
                                      : pbta_pkg::DEN_W'(trial);
         stage_in.lane[j].bits = in_stage.lane[j].bits << 1;
         stage_in.lane[j].quot = {in_stage.lane[j].quot[pbta_pkg::QUOT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

### rtl/pbta_cordic_cell.sv
module pbta_cordic_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [pbta_pkg::STAGE_IDX_W-1:0]     stage_idx,
   input  logic                                 in_valid,
   input  pbta_pkg::cordic_stage_type           in_stage,
   output logic                                 out_valid,
   output pbta_pkg::cordic_stage_type           out_stage
);

   logic                       valid_ff;
   pbta_pkg::cordic_stage_type stage_ff;
   pbta_pkg::cordic_stage_type stage_in;
   logic signed [pbta_pkg::Z_W-1:0] step_angle;

   assign step_angle = $signed(pbta_pkg::atan_q30(int'(stage_idx)));

   // vectoring rotation, no move when y is already zero
   always_comb begin
      logic signed [pbta_pkg::CORDIC_W-1:0] xs;
      logic signed [pbta_pkg::CORDIC_W-1:0] ys;
      logic signed [pbta_pkg::CORDIC_W-1:0] xv;
      logic signed [pbta_pkg::CORDIC_W-1:0] yv;
      logic signed [pbta_pkg::Z_W-1:0]      zv;
      stage_in = in_stage;
      for (int a = 0; a < 2; a++) begin
         xv = $signed(in_stage.axis[a].x);
         yv = $signed(in_stage.axis[a].y);
         zv = $signed(in_stage.axis[a].z);
         xs = xv >>> stage_idx;
         ys = yv >>> stage_idx;
         if (yv > 0) begin
            stage_in.axis[a].x = xv + ys;
            stage_in.axis[a].y = yv - xs;
            stage_in.axis[a].z = zv + step_angle;
         end else if (yv < 0) begin
            stage_in.axis[a].x = xv - ys;
            stage_in.axis[a].y = yv + xs;
            stage_in.axis[a].z = zv - step_angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule
